@@ sv/sra_pkg.sv @@
// Shared types, sizes and codes of the staging ring allocator.
package sra_pkg;

	// Sizes
	localparam int MAX_REGIONS = 16;
	localparam int OFS_W       = 32;
	localparam int TL_W        = 32;
	localparam int ALIGN_W     = 17;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int RC_W        = $clog2(OFS_W + 1);

	localparam logic [OFS_W-1:0] CAP_RESET = OFS_W'(1048576);

	// Opcodes
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_SUBMIT = 2'd1;
	localparam logic [1:0] OP_POLL   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_GRANTED   = 3'd0;
	localparam logic [2:0] ST_WAIT      = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE = 3'd2;
	localparam logic [2:0] ST_BLOCKED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_SUBMITTED = 3'd5;
	localparam logic [2:0] ST_POLLED    = 3'd6;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [OFS_W-1:0]   request_size;
		logic [ALIGN_W-1:0] align_bytes;
		logic [TL_W-1:0]    done_timeline;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [OFS_W-1:0] grant_offset;
		logic [TL_W-1:0]  timeline_out;
	} rsp_t;

	// One region table entry
	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] length;
		logic [TL_W-1:0]  tag;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       retire;
		logic       rem_start;
		logic       rem_load;
		logic       calc;
		logic       grant;
		logic       submit;
		logic       emit;
		logic [2:0] status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       retire_ok;
		logic       end_fast;
		logic       rem_done;
		logic       too_large;
		logic       full;
		logic       space;
		logic       oldest_untagged;
	} sts_t;

endpackage

@@ sv/sra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/sra_rem.sv @@
// Bit-serial remainder unit: region end modulo ring capacity.
module sra_rem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sra_pkg::OFS_W-1:0] dividend,
	input  logic [sra_pkg::OFS_W-1:0] divisor,
	output logic [sra_pkg::OFS_W-1:0] rem,
	output logic                      done
);
	import sra_pkg::*;

	logic [RC_W-1:0]  cnt_q;
	logic             run_q;
	logic             done_q;
	logic [OFS_W-1:0] dvd_q;
	logic [OFS_W:0]   rem_q;
	logic [OFS_W:0]   trial;

	// Shift in the next dividend bit
	assign trial = {rem_q[OFS_W-1:0], dvd_q[OFS_W-1]};

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= RC_W'(OFS_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == RC_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring subtract, one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[OFS_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rem  = rem_q[OFS_W-1:0];
	assign done = done_q;

endmodule

@@ sv/sra_dpath.sv @@
// Datapath: ring pointers, region table, alignment and space tests, result register.
module sra_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sra_pkg::req_t             request,
	input  logic                      cfg_we,
	input  logic [sra_pkg::OFS_W-1:0] cfg_data,
	input  sra_pkg::cmd_t             cmd,
	output sra_pkg::sts_t             sts,
	output logic                      done,
	output sra_pkg::rsp_t             result
);
	import sra_pkg::*;

	// Control state
	logic [OFS_W-1:0] cap_q;
	logic [OFS_W-1:0] head_q;
	logic [OFS_W-1:0] tail_q;
	logic [TL_W-1:0]  tc_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] unsub_q;
	logic             done_q;

	// Payload registers
	req_t             req_q;
	logic [OFS_W-1:0] aligned_s1;
	logic             wrap_s1;
	rsp_t             res_q;

	// Combinational helpers
	entry_t             rd_ent;
	entry_t             wr_ent;
	logic [IDX_W-1:0]   slot;
	logic [CNT_W:0]     slot_sum;
	logic [IDX_W-1:0]   oldest_inc;
	logic [TL_W-1:0]    tl_inc;
	logic [TL_W-1:0]    tl_next;
	logic [OFS_W-1:0]   end_ofs;
	logic [OFS_W-1:0]   end_diff;
	logic               end_ge;
	logic [OFS_W-1:0]   fast_tail;
	logic [ALIGN_W-1:0] am1;
	logic [OFS_W:0]     align_sum;
	logic [OFS_W-1:0]   aligned_raw;
	logic [OFS_W-1:0]   room;
	logic [OFS_W:0]     grant_end;
	logic               live_zero;
	logic [OFS_W-1:0]   rem_val;
	logic               rem_done;

	// Region table
	sra_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_REGIONS)
	) u_table (
		.clk  (clk),
		.we   (cmd.grant),
		.waddr(slot),
		.wdata(wr_ent),
		.raddr(oldest_q),
		.rdata(rd_ent)
	);

	// Tail remainder for region ends far past capacity
	sra_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.rem_start),
		.dividend(end_ofs),
		.divisor (cap_q),
		.rem     (rem_val),
		.done    (rem_done)
	);

	// Slot pointers and next timeline value
	always_comb begin
		slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(live_q);
		if (slot_sum >= (CNT_W+1)'(MAX_REGIONS)) begin
			slot_sum = slot_sum - (CNT_W+1)'(MAX_REGIONS);
		end
		slot = slot_sum[IDX_W-1:0];
		oldest_inc = (oldest_q == IDX_W'(MAX_REGIONS - 1)) ? '0 : oldest_q + 1'b1;
		tl_inc  = tc_q + 1'b1;
		tl_next = (tl_inc == '0) ? TL_W'(1) : tl_inc;
	end

	// Retire: end of the oldest region folded into the ring
	always_comb begin
		end_ofs  = rd_ent.start + rd_ent.length;
		end_ge   = end_ofs >= cap_q;
		end_diff = end_ofs - cap_q;
		if (cap_q == '0 || !end_ge) begin
			fast_tail = end_ofs;
		end else begin
			fast_tail = end_diff;
		end
	end

	// Allocate: align head and test the fit against capacity
	always_comb begin
		am1 = (req_q.align_bytes == '0) ? '0 : req_q.align_bytes - 1'b1;
		align_sum   = {1'b0, head_q} + (OFS_W+1)'(am1);
		aligned_raw = align_sum[OFS_W-1:0] & ~(OFS_W'(am1));
		room        = cap_q - req_q.request_size;
		grant_end   = {1'b0, aligned_s1} + {1'b0, req_q.request_size};
	end

	assign live_zero = (live_q == '0);

	// Status toward the controller
	always_comb begin
		sts.opcode          = req_q.opcode;
		sts.oldest_untagged = (unsub_q == live_q);
		sts.retire_ok       = !live_zero && !sts.oldest_untagged &&
			(rd_ent.tag <= req_q.done_timeline);
		sts.end_fast        = (cap_q == '0) || !end_ge || (end_diff < cap_q);
		sts.rem_done        = rem_done;
		sts.too_large       = req_q.request_size > cap_q;
		sts.full            = (live_q == CNT_W'(MAX_REGIONS));
		if (live_zero) begin
			sts.space = 1'b1;
		end else if (tail_q <= head_q) begin
			sts.space = !wrap_s1 || (req_q.request_size < tail_q);
		end else begin
			sts.space = !wrap_s1 && (grant_end < {1'b0, tail_q});
		end
	end

	// New table entry; its tag takes effect once the next submit lands
	always_comb begin
		wr_ent.start  = aligned_s1;
		wr_ent.length = req_q.request_size;
		wr_ent.tag    = tl_next;
	end

	// Update ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			tc_q     <= '0;
			oldest_q <= '0;
			live_q   <= '0;
			unsub_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.retire) begin
				oldest_q <= oldest_inc;
				live_q   <= live_q - 1'b1;
				if (!cmd.rem_start) begin
					tail_q <= fast_tail;
				end
			end
			if (cmd.rem_load) begin
				tail_q <= rem_val;
			end
			if (cmd.grant) begin
				head_q  <= grant_end[OFS_W-1:0];
				live_q  <= live_q + 1'b1;
				unsub_q <= unsub_q + 1'b1;
			end
			if (cmd.submit) begin
				tc_q    <= tl_next;
				unsub_q <= '0;
			end
		end
	end

	// Hold request, alignment stage and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.calc) begin
			wrap_s1 <= align_sum[OFS_W] || (aligned_raw > room);
			if (align_sum[OFS_W] || (aligned_raw > room)) begin
				aligned_s1 <= '0;
			end else begin
				aligned_s1 <= aligned_raw;
			end
		end
		if (cmd.emit) begin
			res_q.status       <= cmd.status;
			res_q.grant_offset <= cmd.grant ? aligned_s1 : '0;
			if (cmd.submit) begin
				res_q.timeline_out <= tl_next;
			end else if (cmd.status == ST_WAIT) begin
				res_q.timeline_out <= rd_ent.tag;
			end else begin
				res_q.timeline_out <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ sv/sra_ctrl.sv @@
// Controller: sequences retirement, the requested operation and the result strobe.
module sra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sra_pkg::sts_t sts,
	output sra_pkg::cmd_t cmd,
	output logic          busy
);
	import sra_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_REM,
		S_ALIGN,
		S_DECIDE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.retire_ok) begin
					cmd.retire = 1'b1;
					if (sts.end_fast) begin
						state_d = S_READ;
					end else begin
						cmd.rem_start = 1'b1;
						state_d       = S_REM;
					end
				end else begin
					case (sts.opcode)
						OP_ALLOC: begin
							if (sts.too_large) begin
								cmd.emit   = 1'b1;
								cmd.status = ST_TOO_LARGE;
								state_d    = S_IDLE;
							end else if (sts.full) begin
								cmd.emit   = 1'b1;
								cmd.status = ST_FULL;
								state_d    = S_IDLE;
							end else begin
								state_d = S_ALIGN;
							end
						end
						OP_SUBMIT: begin
							cmd.submit = 1'b1;
							cmd.emit   = 1'b1;
							cmd.status = ST_SUBMITTED;
							state_d    = S_IDLE;
						end
						default: begin
							cmd.emit   = 1'b1;
							cmd.status = ST_POLLED;
							state_d    = S_IDLE;
						end
					endcase
				end
			end
			S_REM: begin
				if (sts.rem_done) begin
					cmd.rem_load = 1'b1;
					state_d      = S_READ;
				end
			end
			S_ALIGN: begin
				cmd.calc = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
				if (sts.space) begin
					cmd.grant  = 1'b1;
					cmd.status = ST_GRANTED;
				end else if (sts.oldest_untagged) begin
					cmd.status = ST_BLOCKED;
				end else begin
					cmd.status = ST_WAIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ sv/staging_ring_allocator.sv @@
// Top level of the staging ring allocator: controller, datapath and ports.
// Poll and submit go through request load, table read and tag check to the result;
// allocate adds alignment and decide. Each retired region adds a table read and tag
// check, and the bit-serial remainder unit when its end lies two or more capacities out.
// Throughput: one request at a time; the next is taken the cycle the result shows.
// Reset clears pointers, counts and timeline and loads the 1 MiB capacity; the region
// table holds no reset value and only live entries are read. The receiver cannot stall.
module staging_ring_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  sra_pkg::req_t             request,
	output logic                      done,
	output sra_pkg::rsp_t             result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sra_pkg::OFS_W-1:0] cfg_data
);
	import sra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Capacity writes are always taken
	assign cfg_ready = 1'b1;

	sra_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	sra_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cfg_we  (cfg_valid & cfg_ready),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

@@ sv/sra_checker.sv @@
// Port-level checks of the staging ring allocator and their binding to the top level.
module sra_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input sra_pkg::rsp_t result
);
	import sra_pkg::*;

	// A taken request keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// A result closes the request it belongs to
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// One result per request
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on two cycles in a row");

	// Only a grant carries an offset
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_GRANTED) |-> (result.grant_offset == '0))
		else $error("offset on a request that was not granted");

	// Timeline only on submit and must-wait
	a_timeline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_SUBMITTED) && (result.status != ST_WAIT)
			|-> (result.timeline_out == '0))
		else $error("timeline on a result that carries none");

endmodule

bind staging_ring_allocator sra_checker u_sra_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the staging ring allocator: directed cases, then random phases.
`timescale 1ns / 1ps

module tb_top;
	import sra_pkg::*;

	localparam logic [63:0] OFFSET_MAX   = 64'hFFFF_FFFF;
	localparam logic [63:0] TIMELINE_MAX = 64'hFFFF_FFFF;
	localparam logic [1:0]  OP_SPARE     = 2'd3;
	localparam int          REPORT_LIMIT = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        done;
	rsp_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// Ring state as the testbench expects it
	logic [63:0] ring_cap = 64'(CAP_RESET);
	logic [63:0] ring_head = '0;
	logic [63:0] ring_tail = '0;
	logic [63:0] tl_count = '0;
	logic [63:0] seg_start [MAX_REGIONS];
	logic [63:0] seg_len [MAX_REGIONS];
	logic [63:0] seg_tag [MAX_REGIONS];
	int unsigned oldest_seg = 0;
	int unsigned live_segs = 0;

	rsp_t awaited_outcomes [$];
	int unsigned err_count = 0;
	int unsigned requests_sent = 0;
	int unsigned outcomes_seen = 0;
	int unsigned cap_writes = 0;
	int unsigned status_tally [8];
	bit steady = 1'b0;

	staging_ring_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Retire finished regions, then apply the request to the ring state
	task automatic ring_outcome(input req_t r, output rsp_t e);
		logic [63:0] size, align, am1, sum, aligned, seg_end, tag;
		int unsigned i, k;
		logic wrap, space;
		e = '0;
		size = 64'(r.request_size);
		align = (r.align_bytes == '0) ? 64'd1 : 64'(r.align_bytes);
		while (live_segs > 0) begin
			i = oldest_seg;
			if (seg_tag[i] == 0 || seg_tag[i] > 64'(r.done_timeline))
				break;
			seg_end = (seg_start[i] + seg_len[i]) & OFFSET_MAX;
			ring_tail = (ring_cap != 0) ? seg_end % ring_cap : seg_end;
			oldest_seg = (i + 1) % MAX_REGIONS;
			live_segs--;
		end
		case (r.opcode)
			OP_ALLOC: begin
				if (size > ring_cap) begin
					e.status = ST_TOO_LARGE;
				end else if (live_segs >= MAX_REGIONS) begin
					e.status = ST_FULL;
				end else begin
					am1 = align - 1;
					sum = ring_head + am1;
					wrap = 1'b0;
					aligned = sum & ~am1;
					if (sum > OFFSET_MAX || aligned > ring_cap - size) begin
						aligned = '0;
						wrap = 1'b1;
					end
					if (live_segs == 0)
						space = 1'b1;
					else if (ring_tail <= ring_head)
						space = wrap ? (size < ring_tail) : 1'b1;
					else
						space = wrap ? 1'b0 : (aligned + size < ring_tail);
					if (!space) begin
						tag = seg_tag[oldest_seg];
						if (tag == 0) begin
							e.status = ST_BLOCKED;
						end else begin
							e.status = ST_WAIT;
							e.timeline_out = tag[TL_W-1:0];
						end
					end else begin
						ring_head = (aligned + size) & OFFSET_MAX;
						i = (oldest_seg + live_segs) % MAX_REGIONS;
						seg_start[i] = aligned;
						seg_len[i] = size;
						seg_tag[i] = '0;
						live_segs++;
						e.status = ST_GRANTED;
						e.grant_offset = aligned[OFS_W-1:0];
					end
				end
			end
			OP_SUBMIT: begin
				tl_count = (tl_count + 1) & TIMELINE_MAX;
				if (tl_count == 0)
					tl_count = 1;
				for (k = 0; k < live_segs; k++) begin
					i = (oldest_seg + k) % MAX_REGIONS;
					if (seg_tag[i] == 0)
						seg_tag[i] = tl_count;
				end
				e.status = ST_SUBMITTED;
				e.timeline_out = tl_count[TL_W-1:0];
			end
			default: e.status = ST_POLLED;
		endcase
	endtask

	function automatic req_t make_req(input logic [1:0] op, input logic [31:0] size,
			input logic [16:0] align, input logic [31:0] finished);
		req_t r;
		r.opcode = op;
		r.request_size = size;
		r.align_bytes = align;
		r.done_timeline = finished;
		return r;
	endfunction

	// Present one request and hold it until the block takes it
	task automatic issue(input req_t r);
		rsp_t e;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		ring_outcome(r, e);
		awaited_outcomes = {awaited_outcomes, e};
		status_tally[e.status]++;
		requests_sent++;
	endtask

	// Occasional idle cycles on the request side
	task automatic sender_gap();
		if (!steady && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// Hold off requests until every outstanding result is back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (awaited_outcomes.size() != 0);
	endtask

	task automatic write_capacity(input logic [31:0] value);
		drain_results();
		repeat (4) @(posedge clk);
		repeat ($urandom_range(2, 0)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		ring_cap = 64'(value);
		cap_writes++;
	endtask

	// Compare each result with the oldest expectation
	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("MISMATCH %s at result %0d: expected %0h, got %0h",
				what, outcomes_seen, want, got);
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				flag_mismatch("unexpected result, status", '0, 32'(result.status));
			end else begin
				want = awaited_outcomes.pop_front();
				if (result.status !== want.status)
					flag_mismatch("status", 32'(want.status), 32'(result.status));
				if (result.grant_offset !== want.grant_offset)
					flag_mismatch("grant_offset", want.grant_offset, result.grant_offset);
				if (result.timeline_out !== want.timeline_out)
					flag_mismatch("timeline_out", want.timeline_out, result.timeline_out);
			end
			outcomes_seen++;
		end
	end

	// Build a random request: mostly sizes that fit, with loose ends for noise
	function automatic req_t random_req();
		req_t r;
		int unsigned pick, lim;
		pick = $urandom_range(99);
		if (pick < 58)
			r.opcode = OP_ALLOC;
		else if (pick < 74)
			r.opcode = OP_SUBMIT;
		else if (pick < 95)
			r.opcode = OP_POLL;
		else
			r.opcode = OP_SPARE;
		lim = ring_cap[31:0] / 6;
		pick = $urandom_range(99);
		if (pick < 75)
			r.request_size = $urandom_range(lim, 0);
		else if (pick < 85)
			r.request_size = $urandom_range(64, 0);
		else if (pick < 90)
			r.request_size = ring_cap[31:0];
		else if (pick < 95)
			r.request_size = ring_cap[31:0] + 32'd1;
		else
			r.request_size = $urandom;
		pick = $urandom_range(99);
		if (pick < 60)
			r.align_bytes = 17'(1) << $urandom_range(6, 0);
		else if (pick < 80)
			r.align_bytes = 17'(1) << $urandom_range(16, 0);
		else if (pick < 88)
			r.align_bytes = '0;
		else
			r.align_bytes = 17'($urandom);
		pick = $urandom_range(99);
		if (pick < 65)
			r.done_timeline = 32'(tl_count - 64'($urandom_range(3, 0)));
		else if (pick < 80)
			r.done_timeline = '0;
		else if (pick < 85)
			r.done_timeline = '1;
		else
			r.done_timeline = $urandom;
		return r;
	endfunction

	task automatic test_poll_and_spare_opcode();
		issue(make_req(OP_POLL, '0, 17'd1, '0));
		sender_gap();
		issue(make_req(OP_SPARE, '1, '1, '1));
		sender_gap();
	endtask

	// Too large, exact fit, blocked by an unsubmitted region, must wait, retire
	task automatic test_allocate_basics();
		issue(make_req(OP_ALLOC, '1, 17'd1, '0));
		issue(make_req(OP_ALLOC, ring_cap[31:0], 17'd65536, '0));
		issue(make_req(OP_ALLOC, 32'd16, '0, '0));
		issue(make_req(OP_SUBMIT, '0, 17'd1, '0));
		sender_gap();
		issue(make_req(OP_ALLOC, 32'd16, 17'd1, '0));
		issue(make_req(OP_POLL, '0, 17'd1, tl_count[31:0]));
		sender_gap();
	endtask

	// Fill the region table with odd alignments, one more is refused
	task automatic test_table_full();
		logic [16:0] fill_aligns [4];
		int unsigned n;
		fill_aligns = '{17'd0, 17'd12, 17'h1FFFF, 17'd65536};
		n = MAX_REGIONS - live_segs + 1;
		for (int k = 0; k < n; k++) begin
			issue(make_req(OP_ALLOC, 32'd8, fill_aligns[k % 4], '0));
			sender_gap();
		end
		issue(make_req(OP_SUBMIT, '0, 17'd1, '0));
		issue(make_req(OP_POLL, '0, 17'd1, '1));
	endtask

	// Full-width capacity: push head to the top so aligning it overflows
	task automatic test_alignment_overflow();
		write_capacity('1);
		issue(make_req(OP_ALLOC, 32'hFFFF_FFF0, 17'd1, '0));
		issue(make_req(OP_ALLOC, 32'd1, 17'd65536, '0));
		issue(make_req(OP_SUBMIT, '0, 17'd1, '0));
		issue(make_req(OP_POLL, '0, 17'd1, '1));
	endtask

	task automatic test_random_phase(input logic [31:0] cap, input int unsigned n,
			input bit no_idle);
		write_capacity(cap);
		steady = no_idle;
		repeat (n) begin
			issue(random_req());
			if ($urandom_range(149) == 0)
				drain_results();
			else
				sender_gap();
		end
		steady = 1'b0;
	endtask

	initial begin : run_tests
		logic [31:0] any_cap;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_poll_and_spare_opcode();
		test_allocate_basics();
		test_table_full();
		test_alignment_overflow();

		any_cap = $urandom;
		if (any_cap == '0)
			any_cap = 32'd1;
		test_random_phase(CAP_RESET, 450, 1'b0);
		test_random_phase('1, 400, 1'b1);
		test_random_phase(32'd4096, 400, 1'b0);
		test_random_phase(32'd1, 100, 1'b0);
		test_random_phase(any_cap, 400, 1'b0);
		test_random_phase(32'd300, 250, 1'b0);

		drain_results();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests, %0d results checked, %0d capacity writes, %0d errors",
			requests_sent, outcomes_seen, cap_writes, err_count);
		$display("Outcomes: granted %0d, wait %0d, too large %0d, blocked %0d, full %0d",
			status_tally[ST_GRANTED], status_tally[ST_WAIT], status_tally[ST_TOO_LARGE],
			status_tally[ST_BLOCKED], status_tally[ST_FULL]);
		if (err_count == 0 && awaited_outcomes.size() == 0)
			$display("staging_ring_allocator verification clean");
		else
			$display("staging_ring_allocator verification failed");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin : watchdog
		#100ms;
		$display("Timeout with %0d results outstanding", awaited_outcomes.size());
		$display("staging_ring_allocator verification failed");
		$finish;
	end

endmodule
